// File: hw/rtl/pdcchss_pkg.sv
// Package for the PDCCH search-space CCE hash block: constants, codes, control types.
`default_nettype none

package pdcchss_pkg;

  localparam int MAX_CANDIDATES = 8;
  localparam int NUM_AGG_LEVELS = 5;
  localparam int HASH_MOD       = 65537;
  localparam int REGS_PER_CCE   = 6;

  // floor(x / 6) as (x * 2731) >> 14, exact for x up to 511 * 3
  localparam int NCCE_RECIP = 2731;
  localparam int NCCE_SHIFT = 14;

  localparam int RNTI_W  = 16;
  localparam int LVL_W   = 3;
  localparam int SLOT_W  = 8;
  localparam int CCE_W   = 8;
  localparam int CIDX_W  = 3;
  localparam int STAT_W  = 2;
  localparam int MCNT_W  = 4;
  localparam int HASH_W  = 17;
  localparam int PROD_W  = 32;
  localparam int MULT_W  = 16;

  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CORESET_IDENT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORESET_PRB      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORESET_SYMBOLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UE_SPECIFIC      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_COUNTS = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_CAND   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_SMALL = 2'd3;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_YMOD = 2'd1,
    DIV_OFF  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic              load;
    logic              div_start;
    div_sel_t          div_sel;
    logic              ld_ncce;
    logic              ld_ymod;
    logic              ld_off;
    logic              hash_mul;
    logic              hash_red;
    logic              y_zero;
    logic              ld_cce;
    logic              set_err;
    logic [STAT_W-1:0] err_code;
    logic              m_inc;
  } cmd_t;

  typedef struct packed {
    logic bad_lvl;
    logic m_zero;
    logic too_small;
    logic cnt_zero;
    logic div_done;
    logic last_cand;
    logic ue;
  } sts_t;

  // hash multiplier chosen by coreset id mod 3
  function automatic logic [MULT_W-1:0] hash_mult(input logic [3:0] ident);
    logic [MULT_W-1:0] a;
    case (ident)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: a = 16'd39827;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       a = 16'd39829;
      default:                              a = 16'd39839;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pdcchss_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pdcchss_div import pdcchss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo,
  output logic [DIV_DEN_W-1:0]      rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   trial;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/pdcchss_dp.sv
// Datapath: configuration registers, hash loop, shared divider and result registers.
`default_nettype none

module pdcchss_dp import pdcchss_pkg::*; #(
  parameter int MAX_CAND   = MAX_CANDIDATES,
  parameter int NUM_LEVELS = NUM_AGG_LEVELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [RNTI_W-1:0]     in_rnti,
  input  wire logic [LVL_W-1:0]      in_agg_level,
  input  wire logic [SLOT_W-1:0]     in_slot_index,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic [CCE_W-1:0]           out_first_cce,
  output logic [CIDX_W-1:0]          out_candidate_index,
  output logic [STAT_W-1:0]          out_status,
  output logic                       out_last
);

  logic [3:0]  cfg_ident_r;
  logic [8:0]  cfg_prb_r;
  logic [1:0]  cfg_sym_r;
  logic        cfg_ue_r;
  logic [19:0] cfg_counts_r;

  logic [LVL_W-1:0]  lvl_r;
  logic [SLOT_W-1:0] cnt_r;
  logic [MCNT_W-1:0] mcnt_r;
  logic [MCNT_W-1:0] m_r;
  logic [CCE_W-1:0]  ncce_r;
  logic [HASH_W-1:0] y_r;
  logic [PROD_W-1:0] prod_r;
  logic [CCE_W-1:0]  ymod_r;
  logic [CCE_W-1:0]  off_r;
  logic [CCE_W-1:0]  out_cce_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_last_r;

  logic [MCNT_W-1:0]    nib;
  logic [MCNT_W-1:0]    mcnt_nxt;
  logic [CCE_W-1:0]     ncl;
  logic [DIV_DEN_W-1:0] lm;
  logic [10:0]          prb_sym;
  logic [22:0]          ncce_prod;
  logic [CCE_W-1:0]     ncce;
  logic [MULT_W-1:0]    mult_a;
  logic [HASH_W-1:0]    y_red;
  logic [HASH_W:0]      y_wrap;
  logic [8:0]           sum;
  logic [8:0]           sum_red;
  logic [CCE_W-1:0]     cce;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ident_r  <= 4'd0;
      cfg_prb_r    <= 9'd48;
      cfg_sym_r    <= 2'd1;
      cfg_ue_r     <= 1'b1;
      cfg_counts_r <= 20'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CORESET_IDENT:    cfg_ident_r  <= cfg_wdata[3:0];
        REG_CORESET_PRB:      cfg_prb_r    <= cfg_wdata[8:0];
        REG_CORESET_SYMBOLS:  cfg_sym_r    <= cfg_wdata[1:0];
        REG_UE_SPECIFIC:      cfg_ue_r     <= cfg_wdata[0];
        REG_CANDIDATE_COUNTS: cfg_counts_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (in_agg_level)
      3'd0:    nib = cfg_counts_r[3:0];
      3'd1:    nib = cfg_counts_r[7:4];
      3'd2:    nib = cfg_counts_r[11:8];
      3'd3:    nib = cfg_counts_r[15:12];
      3'd4:    nib = cfg_counts_r[19:16];
      default: nib = '0;
    endcase
    mcnt_nxt = (nib > MCNT_W'(MAX_CAND)) ? MCNT_W'(MAX_CAND) : nib;
  end

  always_comb begin
    ncl       = ncce_r >> lvl_r;
    lm        = DIV_DEN_W'({4'd0, mcnt_r} << lvl_r);
    prb_sym   = 11'(11'(cfg_prb_r) * 11'(cfg_sym_r));
    ncce_prod = 23'(prb_sym) * 23'(NCCE_RECIP);
    ncce      = ncce_prod[NCCE_SHIFT +: CCE_W];
    mult_a    = hash_mult(cfg_ident_r);
    // 2^16 == -1 mod 65537, so fold the high half back with a subtract
    y_wrap    = (HASH_W+1)'(prod_r[15:0]) + (HASH_W+1)'(HASH_MOD)
                - (HASH_W+1)'(prod_r[31:16]);
    y_red     = (prod_r[15:0] >= prod_r[31:16])
                ? HASH_W'(prod_r[15:0] - prod_r[31:16]) : y_wrap[HASH_W-1:0];
    sum       = 9'(ymod_r) + 9'(off_r);
    sum_red   = (sum >= 9'(ncl)) ? sum - 9'(ncl) : sum;
    cce       = sum_red[CCE_W-1:0] << lvl_r;
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_YMOD: begin
        div_num = y_r;
        div_den = ncl;
      end
      DIV_OFF: begin
        div_num = DIV_NUM_W'(12'(12'(m_r) * 12'(ncce_r)));
        div_den = lm;
      end
      default: begin
        div_num = '0;
        div_den = DIV_DEN_W'(1);
      end
    endcase
  end

  pdcchss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl_r  <= in_agg_level;
      cnt_r  <= in_slot_index;
      mcnt_r <= mcnt_nxt;
      y_r    <= HASH_W'(in_rnti);
      m_r    <= '0;
    end else begin
      if (cmd.y_zero) begin
        y_r <= '0;
      end else if (cmd.hash_red) begin
        y_r <= y_red;
      end
      if (cmd.hash_red) begin
        cnt_r <= cnt_r - SLOT_W'(1);
      end
      if (cmd.m_inc) begin
        m_r <= m_r + MCNT_W'(1);
      end
    end
    if (cmd.hash_mul) begin
      prod_r <= PROD_W'(33'(mult_a) * 33'(y_r));
    end
    if (cmd.ld_ncce) begin
      ncce_r <= ncce;
    end
    if (cmd.ld_ymod) begin
      ymod_r <= div_rem;
    end
    if (cmd.ld_off) begin
      off_r <= div_quo[CCE_W-1:0];
    end
    if (cmd.set_err) begin
      out_cce_r    <= '0;
      out_status_r <= cmd.err_code;
      out_last_r   <= 1'b1;
    end else if (cmd.ld_cce) begin
      out_cce_r    <= cce;
      out_status_r <= ST_OK;
      out_last_r   <= sts.last_cand;
    end
  end

  always_comb begin
    sts.bad_lvl   = lvl_r >= LVL_W'(NUM_LEVELS);
    sts.m_zero    = mcnt_r == '0;
    sts.too_small = ncl == '0;
    sts.cnt_zero  = cnt_r == '0;
    sts.div_done  = div_done;
    sts.last_cand = (5'(m_r) + 5'd1) == 5'(mcnt_r);
    sts.ue        = cfg_ue_r;
  end

  assign out_first_cce       = out_cce_r;
  assign out_candidate_index = m_r[CIDX_W-1:0];
  assign out_status          = out_status_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/pdcchss_ctrl.sv
// Controller state machine sequencing checks, hash loop, divisions and results.
`default_nettype none

module pdcchss_ctrl import pdcchss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHK1   = 10'b00_0000_0010,
    S_CHK2   = 10'b00_0000_0100,
    S_HMUL   = 10'b00_0000_1000,
    S_HRED   = 10'b00_0001_0000,
    S_YSTART = 10'b00_0010_0000,
    S_YDIV   = 10'b00_0100_0000,
    S_OSTART = 10'b00_1000_0000,
    S_ODIV   = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   err_r,   err_nxt;
  // first cycle of S_OUT after the offset lands: result registers load, nothing shown yet
  logic   cce_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.div_sel = DIV_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK1;
        end
      end
      S_CHK1: begin
        if (sts.bad_lvl) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_BAD_LEVEL;
          err_nxt      = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.m_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_NO_CAND;
          err_nxt      = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.ld_ncce = 1'b1;
          state_nxt   = S_CHK2;
        end
      end
      S_CHK2: begin
        if (sts.too_small) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_TOO_SMALL;
          err_nxt      = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.ue) begin
          state_nxt = S_HMUL;
        end else begin
          cmd.y_zero = 1'b1;
          state_nxt  = S_YSTART;
        end
      end
      S_HMUL: begin
        cmd.hash_mul = 1'b1;
        state_nxt    = S_HRED;
      end
      S_HRED: begin
        cmd.hash_red = 1'b1;
        state_nxt    = sts.cnt_zero ? S_YSTART : S_HMUL;
      end
      S_YSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_YMOD;
        state_nxt     = S_YDIV;
      end
      S_YDIV: begin
        cmd.div_sel = DIV_YMOD;
        if (sts.div_done) begin
          cmd.ld_ymod = 1'b1;
          state_nxt   = S_OSTART;
        end
      end
      S_OSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OFF;
        state_nxt     = S_ODIV;
      end
      S_ODIV: begin
        cmd.div_sel = DIV_OFF;
        if (sts.div_done) begin
          cmd.ld_off = 1'b1;
          state_nxt  = S_OUT;
          err_nxt    = 1'b0;
        end
      end
      S_OUT: begin
        if (cce_pend_r) begin
          cmd.ld_cce = 1'b1;
        end else if (!out_stall) begin
          if (err_r || sts.last_cand) begin
            err_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            cmd.m_inc = 1'b1;
            state_nxt = S_OSTART;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        err_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cce_pend_r <= 1'b0;
    end else begin
      cce_pend_r <= (state_r == S_ODIV) && sts.div_done;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = (state_r == S_OUT) && !cce_pend_r;

endmodule

`default_nettype wire

// File: hw/rtl/pdcch_search_space_cce_hash.sv
// Top level of the PDCCH search-space CCE hash block.
// One request at a time; in_stall stays high from acceptance until the last result is taken.
// Error results are raised in the check states: bad level or no candidates in S_CHK1, too small in S_CHK2.
// Before the last good result come the hash loop (an S_HMUL, S_HRED pair per step, slot_index+1
// steps, none in a common search space), the Y mod division, and the offset division per candidate.
// Synchronous active-low reset returns to idle and loads the register reset values.
`default_nettype none

module pdcch_search_space_cce_hash import pdcchss_pkg::*; #(
  parameter int MAX_CAND   = MAX_CANDIDATES,
  parameter int NUM_LEVELS = NUM_AGG_LEVELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [RNTI_W-1:0]     in_rnti,
  input  wire logic [LVL_W-1:0]      in_agg_level,
  input  wire logic [SLOT_W-1:0]     in_slot_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CCE_W-1:0]           out_first_cce,
  output logic [CIDX_W-1:0]          out_candidate_index,
  output logic [STAT_W-1:0]          out_status,
  output logic                       out_last
);

  cmd_t cmd;
  sts_t sts;

  pdcchss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdcchss_dp #(
    .MAX_CAND   (MAX_CAND),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_rnti             (in_rnti),
    .in_agg_level        (in_agg_level),
    .in_slot_index       (in_slot_index),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_first_cce       (out_first_cce),
    .out_candidate_index (out_candidate_index),
    .out_status          (out_status),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/pdcchss_chk.sv
// Port-level checker for the PDCCH search-space CCE hash block, with its bind.
`default_nettype none

module pdcchss_chk import pdcchss_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [CCE_W-1:0]  out_first_cce,
  input wire logic [CIDX_W-1:0] out_candidate_index,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic              out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while a result is pending");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      out_last && (out_first_cce == '0) && (out_candidate_index == '0))
    else $error("error result not a lone zeroed last result");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> in_stall)
    else $error("request taken before the last result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid && !in_stall)
    else $error("block not idle after last result");

endmodule

bind pdcch_search_space_cce_hash pdcchss_chk u_chk (.*);

`default_nettype wire
